>>> rtl/selective_repeat_receive_window_defines.svh
// ----------------------------------------------------------------------------
// srrw assertion macros
// shared assertion forms for the receive window, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication
`define SRRW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// shared codes, defaults and state encoding of the receive window
// ----------------------------------------------------------------------------
package srrw_pkg;

	// parameter defaults
	localparam int DEF_MAX_WINDOW    = 8;
	localparam int DEF_SEGMENT_BYTES = 1024;
	localparam int DEF_TAG_BITS      = 16;

	// packet kinds
	localparam logic [1:0] KIND_SYN = 2'd0;
	localparam logic [1:0] KIND_DAT = 2'd1;
	localparam logic [1:0] KIND_FIN = 2'd2;
	localparam logic [1:0] KIND_RST = 2'd3;

	// result kinds
	localparam logic [1:0] RES_ACK     = 2'd0;
	localparam logic [1:0] RES_DELIVER = 2'd1;
	localparam logic [1:0] RES_CLOSE   = 2'd2;

	// back-end sequencer
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_EXEC   = 9'b000000010,
		ST_DIV    = 9'b000000100,
		ST_APPLY  = 9'b000001000,
		ST_WALK   = 9'b000010000,
		ST_FINISH = 9'b000100000,
		ST_DELIV  = 9'b001000000,
		ST_CLOSE  = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

>>> rtl/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// receive side of a selective-repeat link: reorder window, acks, delivery
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue lets
// two items wait while the sequencer works. Results appear one per cycle on
// the result ports, marked by res_valid for one cycle each, and must be taken
// as they come. The sequencer picks an item up from the queue in ST_IDLE. A
// SYN or a FIN that does not close goes from ST_EXEC to ST_DONE; a closing
// FIN or an RST goes on to ST_DELIV. A data item may step through ST_DIV for
// each window slot that the offset search steps over, then ST_APPLY, ST_WALK
// for each ack of the in-order walk, ST_FINISH, ST_DELIV for each delivered
// slot and ST_CLOSE when the link closes. Offset search and slot walk are
// sequential. The last result of an item leaves in the cycle after ST_DONE.
// The window state needs no clearing pass after reset.
module selective_repeat_receive_window import srrw_pkg::*; #(
	parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
	parameter int SEGMENT_BYTES = DEF_SEGMENT_BYTES,
	parameter int TAG_BITS      = DEF_TAG_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [31:0]         seq_number,
	input  logic [10:0]         payload_length,
	input  logic [3:0]          window_slots,
	input  logic [TAG_BITS-1:0] payload_tag,
	output logic                res_valid,
	output logic [1:0]          kind_res,
	output logic [31:0]         ack_number,
	output logic                repeated_ack,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [10:0]         out_length,
	output logic                last
);

	localparam int WIN_W = $clog2(MAX_WINDOW + 1);

	logic                q_valid;
	logic                q_pop;
	logic [1:0]          q_kind;
	logic [31:0]         q_seq;
	logic [10:0]         q_len;
	logic [WIN_W-1:0]    q_win;
	logic [TAG_BITS-1:0] q_tag;

	// accept, clamp and queue
	srrw_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.TAG_BITS  (TAG_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.seq_number    (seq_number),
		.payload_length(payload_length),
		.window_slots  (window_slots),
		.payload_tag   (payload_tag),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_kind        (q_kind),
		.q_seq         (q_seq),
		.q_len         (q_len),
		.q_win         (q_win),
		.q_tag         (q_tag)
	);

	// window sequencer
	srrw_back #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SEGMENT_BYTES(SEGMENT_BYTES),
		.TAG_BITS     (TAG_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_kind      (q_kind),
		.q_seq       (q_seq),
		.q_len       (q_len),
		.q_win       (q_win),
		.q_tag       (q_tag),
		.res_valid   (res_valid),
		.kind_res    (kind_res),
		.ack_number  (ack_number),
		.repeated_ack(repeated_ack),
		.out_tag     (out_tag),
		.out_length  (out_length),
		.last        (last)
	);

endmodule

>>> rtl/srrw_front.sv
// ----------------------------------------------------------------------------
// srrw_front
// accepts items, clamps the announced window size and queues them
// ----------------------------------------------------------------------------
module srrw_front import srrw_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int TAG_BITS   = DEF_TAG_BITS,
	localparam int WIN_W     = $clog2(MAX_WINDOW + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [31:0]         seq_number,
	input  logic [10:0]         payload_length,
	input  logic [3:0]          window_slots,
	input  logic [TAG_BITS-1:0] payload_tag,
	output logic                q_valid,
	input  logic                q_pop,
	output logic [1:0]          q_kind,
	output logic [31:0]         q_seq,
	output logic [10:0]         q_len,
	output logic [WIN_W-1:0]    q_win,
	output logic [TAG_BITS-1:0] q_tag
);

	logic [1:0]          kind_q [2];
	logic [31:0]         seq_q  [2];
	logic [10:0]         len_q  [2];
	logic [WIN_W-1:0]    win_q  [2];
	logic [TAG_BITS-1:0] tag_q  [2];
	logic [1:0]          count_q;
	logic                wr_q;
	logic                rd_q;
	logic                push;
	logic [WIN_W-1:0]    win_c;

	// clamp announced window size to 1..MAX_WINDOW
	always_comb begin
		if (window_slots == 4'd0) begin
			win_c = WIN_W'(1);
		end else if (32'(window_slots) > 32'(MAX_WINDOW)) begin
			win_c = WIN_W'(MAX_WINDOW);
		end else begin
			win_c = WIN_W'(window_slots);
		end
	end

	assign push    = start && !busy;
	assign busy    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_kind  = kind_q[rd_q];
	assign q_seq   = seq_q[rd_q];
	assign q_len   = len_q[rd_q];
	assign q_win   = win_q[rd_q];
	assign q_tag   = tag_q[rd_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_q] <= kind;
			seq_q[wr_q]  <= seq_number;
			len_q[wr_q]  <= payload_length;
			win_q[wr_q]  <= win_c;
			tag_q[wr_q]  <= payload_tag;
		end
	end

endmodule

>>> rtl/srrw_back.sv
// ----------------------------------------------------------------------------
// srrw_back
// window state, slot store and the sequencer that issues at most one result a cycle
// ----------------------------------------------------------------------------
`include "selective_repeat_receive_window_defines.svh"

module srrw_back import srrw_pkg::*; #(
	parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
	parameter int SEGMENT_BYTES = DEF_SEGMENT_BYTES,
	parameter int TAG_BITS      = DEF_TAG_BITS,
	localparam int WIN_W        = $clog2(MAX_WINDOW + 1),
	localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  logic [1:0]          q_kind,
	input  logic [31:0]         q_seq,
	input  logic [10:0]         q_len,
	input  logic [WIN_W-1:0]    q_win,
	input  logic [TAG_BITS-1:0] q_tag,
	output logic                res_valid,
	output logic [1:0]          kind_res,
	output logic [31:0]         ack_number,
	output logic                repeated_ack,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [10:0]         out_length,
	output logic                last
);

	localparam logic [31:0]      SEG  = 32'(SEGMENT_BYTES);
	localparam logic [WIN_W-1:0] WMAX = WIN_W'(MAX_WINDOW);

	state_t state_q;

	// current item
	logic [1:0]          kind_q;
	logic [31:0]         seq_q;
	logic [10:0]         len_q;
	logic [WIN_W-1:0]    win_q;
	logic [TAG_BITS-1:0] tag_q;

	// window state
	logic [MAX_WINDOW-1:0] valid_q;
	logic [31:0]           slot_seq_q [MAX_WINDOW];
	logic [10:0]           slot_len_q [MAX_WINDOW];
	logic [TAG_BITS-1:0]   slot_tag_q [MAX_WINDOW];
	logic [WIN_W-1:0]      wsize_q;
	logic [31:0]           base_q;
	logic [31:0]           cum_q;
	logic                  fin_known_q;
	logic [31:0]           fin_seq_q;
	logic                  mav_q;
	logic [31:0]           mas_q;

	// sequencer working registers
	logic [31:0]      off_q;
	logic [WIN_W-1:0] idx_q;
	logic [WIN_W-1:0] ptr_q;
	logic [WIN_W-1:0] lim_q;
	logic             close_q;

	// pending result, held back until the next result or the end of the item shows whether it is the last
	logic                pend_q;
	logic [1:0]          pkind_q;
	logic [31:0]         pack_q;
	logic                prep_q;
	logic [TAG_BITS-1:0] ptag_q;
	logic [10:0]         plen_q;

	// generated result this cycle
	logic                gen_v;
	logic                gen_is_ack;
	logic [1:0]          gen_kind;
	logic [31:0]         gen_ack;
	logic [TAG_BITS-1:0] gen_tag;
	logic [10:0]         gen_len;
	logic                gen_rep;

	logic [IDX_W-1:0] ptr_i;
	logic             walk_ok;
	logic             deliv_ok;
	logic             fin_hit;
	logic [31:0]      slot_end;

	assign ptr_i    = ptr_q[IDX_W-1:0];
	assign walk_ok  = (ptr_q < win_q) && valid_q[ptr_i];
	assign deliv_ok = (ptr_q < lim_q) && (ptr_q < wsize_q) && valid_q[ptr_i];
	assign fin_hit  = fin_known_q && (cum_q == fin_seq_q);
	assign slot_end = slot_seq_q[ptr_i] + 32'(slot_len_q[ptr_i]);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	// result generation
	always_comb begin
		gen_v      = 1'b0;
		gen_is_ack = 1'b1;
		gen_kind   = RES_ACK;
		gen_ack    = 32'd0;
		gen_tag    = '0;
		gen_len    = 11'd0;
		unique case (state_q)
			ST_EXEC: begin
				if (kind_q == KIND_SYN) begin
					gen_v   = 1'b1;
					gen_ack = seq_q;
				end
			end
			ST_DIV: begin
				if (off_q >= SEG && (idx_q + WIN_W'(1)) == win_q) begin
					gen_v   = 1'b1;
					gen_ack = seq_q + SEG;
				end
			end
			ST_APPLY: begin
				if (seq_q == cum_q) begin
					gen_v   = 1'b1;
					gen_ack = seq_q + 32'(len_q);
				end else if (seq_q < cum_q) begin
					gen_v   = 1'b1;
					gen_ack = seq_q + SEG;
				end
			end
			ST_WALK: begin
				if (walk_ok) begin
					gen_v   = 1'b1;
					gen_ack = slot_end;
				end
			end
			ST_DELIV: begin
				if (deliv_ok) begin
					gen_v      = 1'b1;
					gen_is_ack = 1'b0;
					gen_kind   = RES_DELIVER;
					gen_tag    = slot_tag_q[ptr_i];
					gen_len    = slot_len_q[ptr_i];
				end
			end
			ST_CLOSE: begin
				gen_v    = 1'b1;
				gen_kind = RES_CLOSE;
			end
			ST_IDLE, ST_FINISH, ST_DONE: begin
			end
			default: begin
			end
		endcase
		gen_rep = gen_is_ack && mav_q && (gen_ack < mas_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			wsize_q     <= '0;
			base_q      <= 32'd0;
			cum_q       <= 32'd0;
			fin_known_q <= 1'b0;
			fin_seq_q   <= 32'd0;
			mav_q       <= 1'b0;
			mas_q       <= 32'd0;
			pend_q      <= 1'b0;
			res_valid   <= 1'b0;
			close_q     <= 1'b0;
		end else begin
			// highest ack tracking
			if (gen_v && gen_is_ack && !gen_rep) begin
				mas_q <= gen_ack;
				mav_q <= 1'b1;
			end

			// output staging
			res_valid <= pend_q && (gen_v || state_q == ST_DONE);
			if (gen_v) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_DONE) begin
				pend_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (kind_q)
						KIND_SYN: begin
							valid_q     <= '0;
							wsize_q     <= '0;
							base_q      <= 32'd0;
							cum_q       <= 32'd0;
							fin_known_q <= 1'b0;
							fin_seq_q   <= 32'd0;
							state_q     <= ST_DONE;
						end
						KIND_DAT: begin
							if (win_q != wsize_q) begin
								wsize_q <= win_q;
								valid_q <= '0;
							end
							state_q <= ST_DIV;
						end
						KIND_FIN: begin
							fin_seq_q   <= seq_q;
							fin_known_q <= 1'b1;
							close_q     <= 1'b1;
							state_q     <= (seq_q == cum_q) ? ST_DELIV : ST_DONE;
						end
						KIND_RST: begin
							close_q <= 1'b1;
							state_q <= ST_DELIV;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DIV: begin
					if (off_q >= SEG) begin
						if ((idx_q + WIN_W'(1)) == win_q) begin
							state_q <= ST_DONE;
						end
					end else begin
						valid_q[idx_q[IDX_W-1:0]] <= 1'b1;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (seq_q == cum_q) begin
						cum_q   <= seq_q + 32'(len_q);
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_WALK: begin
					if (walk_ok) begin
						cum_q <= slot_end;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_hit) begin
						close_q <= 1'b1;
						state_q <= ST_DELIV;
					end else if (ptr_q == win_q) begin
						close_q <= 1'b0;
						state_q <= ST_DELIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DELIV: begin
					if (!deliv_ok) begin
						if (close_q) begin
							state_q <= ST_CLOSE;
						end else begin
							valid_q <= '0;
							base_q  <= cum_q;
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLOSE: begin
					valid_q     <= '0;
					wsize_q     <= '0;
					base_q      <= 32'd0;
					cum_q       <= 32'd0;
					fin_known_q <= 1'b0;
					fin_seq_q   <= 32'd0;
					close_q     <= 1'b0;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item, slot payload and working registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_kind;
			seq_q  <= q_seq;
			len_q  <= q_len;
			win_q  <= q_win;
			tag_q  <= q_tag;
			ptr_q  <= '0;
			lim_q  <= WMAX;
		end
		if (state_q == ST_EXEC) begin
			off_q <= seq_q - base_q;
			idx_q <= '0;
		end
		if (state_q == ST_DIV && off_q >= SEG) begin
			off_q <= off_q - SEG;
			idx_q <= idx_q + WIN_W'(1);
		end
		if (state_q == ST_APPLY) begin
			slot_seq_q[idx_q[IDX_W-1:0]] <= seq_q;
			slot_len_q[idx_q[IDX_W-1:0]] <= len_q;
			slot_tag_q[idx_q[IDX_W-1:0]] <= tag_q;
			ptr_q <= (seq_q == cum_q) ? idx_q + WIN_W'(1) : idx_q;
		end
		if (state_q == ST_WALK && walk_ok) begin
			ptr_q <= ptr_q + WIN_W'(1);
		end
		if (state_q == ST_FINISH) begin
			ptr_q <= '0;
			if (fin_hit) begin
				lim_q <= (ptr_q == win_q) ? win_q : ptr_q + WIN_W'(1);
			end else begin
				lim_q <= win_q;
			end
		end
		if (state_q == ST_DELIV && deliv_ok) begin
			ptr_q <= ptr_q + WIN_W'(1);
		end
		// pending result and output register
		if (gen_v) begin
			pkind_q <= gen_kind;
			pack_q  <= gen_ack;
			prep_q  <= gen_rep;
			ptag_q  <= gen_tag;
			plen_q  <= gen_len;
		end
		if (gen_v || state_q == ST_DONE) begin
			kind_res     <= pkind_q;
			ack_number   <= pack_q;
			repeated_ack <= prep_q;
			out_tag      <= ptag_q;
			out_length   <= plen_q;
			last         <= !gen_v;
		end
	end

	// checks
	`SRRW_ASSERT_IMPL(a_pop_idle, q_pop, state_q == ST_IDLE && !pend_q, "pop while busy")
	`SRRW_ASSERT_IMPL(a_deliv_zero, res_valid && kind_res == RES_DELIVER,
		ack_number == 32'd0 && !repeated_ack, "delivery carries an ack")
	`SRRW_ASSERT_IMPL(a_close_last, res_valid && kind_res == RES_CLOSE,
		last && ack_number == 32'd0, "closing ack not last")
	`SRRW_ASSERT_NEXT(a_done_idle, state_q == ST_DONE, state_q == ST_IDLE && !pend_q,
		"done did not return to idle")

endmodule

>>> bench/selective_repeat_receive_window_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_tb
// Drives packet descriptors into the receive window and checks every ack,
// delivery and closing ack against a cycle-free predictor of the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selective_repeat_receive_window_tb;
	import srrw_pkg::*;

	localparam int SLOTS     = DEF_MAX_WINDOW;
	localparam int SEG       = DEF_SEGMENT_BYTES;
	localparam int IDLE_LIM  = 3000;
	localparam int N_RANDOM  = 250;

	// one result of the block
	typedef struct {
		logic [1:0]  kind;
		logic [31:0] ack;
		logic        rep;
		logic [15:0] tag;
		logic [10:0] len;
		logic        last;
	} reply_t;

	// predictor of the window and store of expected replies
	class rx_window_tracker;
		reply_t      pending[$];
		int          errors;
		bit          valid_q[SLOTS];
		logic [31:0] seq_q[SLOTS];
		logic [10:0] len_q[SLOTS];
		logic [15:0] tag_q[SLOTS];
		logic [3:0]  wsize;
		logic [31:0] base;
		logic [31:0] cum;
		bit          fin_seen;
		logic [31:0] fin_at;
		bit          top_valid;
		logic [31:0] top_ack;

		function new();
			errors = 0;
			top_valid = 0;
			top_ack = 0;
			clear_session();
		endfunction

		function void clear_slots();
			foreach (valid_q[i]) valid_q[i] = 0;
		endfunction

		function void clear_session();
			clear_slots();
			wsize = 0;
			base = 0;
			cum = 0;
			fin_seen = 0;
			fin_at = 0;
		endfunction

		function void push(logic [1:0] k, logic [31:0] a, logic r, logic [15:0] t,
				logic [10:0] l);
			reply_t e;
			e.kind = k; e.ack = a; e.rep = r; e.tag = t; e.len = l; e.last = 0;
			pending.push_back(e);
		endfunction

		// repeated flag follows the highest ack sent so far
		function void ack_out(logic [1:0] k, logic [31:0] n);
			logic r;
			r = 0;
			if (top_valid && n < top_ack) r = 1;
			else begin
				top_ack = n;
				top_valid = 1;
			end
			push(k, n, r, 0, 0);
		endfunction

		function void deliver(int lim);
			for (int i = 0; i < lim && i < wsize && i < SLOTS && valid_q[i]; i++)
				push(RES_DELIVER, 0, 0, tag_q[i], len_q[i]);
		endfunction

		function void close_out();
			ack_out(RES_CLOSE, 0);
			clear_session();
		endfunction

		function void note_packet(logic [1:0] k, logic [31:0] s, logic [10:0] l,
				logic [3:0] w_in, logic [15:0] t);
			int n0;
			int idx;
			logic [3:0] w;
			logic [31:0] off;
			n0 = pending.size();
			if (k == KIND_SYN) begin
				ack_out(RES_ACK, s);
				clear_session();
			end else if (k == KIND_DAT) begin
				w = (w_in == 0) ? 4'd1 : (w_in > SLOTS ? 4'(SLOTS) : w_in);
				if (w != wsize) begin
					wsize = w;
					clear_slots();
				end
				off = (s - base) / SEG;
				if (off >= w) ack_out(RES_ACK, s + SEG);
				else begin
					idx = off;
					valid_q[idx] = 1;
					seq_q[idx] = s;
					len_q[idx] = l;
					tag_q[idx] = t;
					if (s == cum) begin
						cum = s + l;
						ack_out(RES_ACK, cum);
						idx++;
						while (idx < w && valid_q[idx]) begin
							cum = seq_q[idx] + len_q[idx];
							ack_out(RES_ACK, cum);
							idx++;
						end
					end else if (s < cum) ack_out(RES_ACK, s + SEG);
					if (fin_seen && cum == fin_at) begin
						deliver((idx + 1 > w) ? w : idx + 1);
						close_out();
					end else if (idx == w) begin
						deliver(w);
						clear_slots();
						base = cum;
					end
				end
			end else if (k == KIND_FIN) begin
				fin_at = s;
				fin_seen = 1;
				if (s == cum) begin
					deliver(SLOTS);
					close_out();
				end
			end else begin
				deliver(SLOTS);
				close_out();
			end
			if (pending.size() > n0) pending[pending.size() - 1].last = 1;
		endfunction

		function void check_result(reply_t got);
			reply_t e;
			if (pending.size() == 0) begin
				$error("unexpected result kind_res=%0d ack_number=%0h", got.kind, got.ack);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind_res expected %0d actual %0d", e.kind, got.kind); errors++;
			end
			if (got.ack !== e.ack) begin
				$error("ack_number expected %0h actual %0h", e.ack, got.ack); errors++;
			end
			if (got.rep !== e.rep) begin
				$error("repeated_ack expected %0d actual %0d", e.rep, got.rep); errors++;
			end
			if (got.tag !== e.tag) begin
				$error("out_tag expected %0h actual %0h", e.tag, got.tag); errors++;
			end
			if (got.len !== e.len) begin
				$error("out_length expected %0d actual %0d", e.len, got.len); errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [31:0] seq_number;
	logic [10:0] payload_length;
	logic [3:0]  window_slots;
	logic [15:0] payload_tag;
	logic        res_valid;
	logic [1:0]  kind_res;
	logic [31:0] ack_number;
	logic        repeated_ack;
	logic [15:0] out_tag;
	logic [10:0] out_length;
	logic        last;

	rx_window_tracker tracker = new();
	int          idle_cycles;
	logic [3:0]  sess_win;

	selective_repeat_receive_window dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .seq_number(seq_number), .payload_length(payload_length),
		.window_slots(window_slots), .payload_tag(payload_tag),
		.res_valid(res_valid), .kind_res(kind_res), .ack_number(ack_number),
		.repeated_ack(repeated_ack), .out_tag(out_tag), .out_length(out_length),
		.last(last)
	);

	// clock
	initial clk = 0;
	always #5 clk = ~clk;

	// result capture
	always @(posedge clk) begin
		reply_t got;
		if (arst_n && res_valid) begin
			got.kind = kind_res; got.ack = ack_number; got.rep = repeated_ack;
			got.tag = out_tag; got.len = out_length; got.last = last;
			tracker.check_result(got);
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if (!arst_n || res_valid || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("selective_repeat_receive_window_tb failed");
			$finish;
		end
	end

	// offer one item after a random gap and hold it until taken
	task automatic send_item(logic [1:0] k, logic [31:0] s, logic [10:0] l,
			logic [3:0] w, logic [15:0] t);
		int gap;
		gap = $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			start <= 0;
		end
		@(negedge clk);
		start <= 1;
		kind <= k; seq_number <= s; payload_length <= l;
		window_slots <= w; payload_tag <= t;
		do @(posedge clk); while (busy);
		tracker.note_packet(k, s, l, w, t);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one random item, mostly well-formed traffic for the current session
	task automatic random_item();
		int r;
		logic [31:0] s;
		r = $urandom_range(0, 99);
		s = tracker.base + $urandom_range(0, SLOTS - 1) * SEG;
		if (r < 68) begin
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_DAT, s, $urandom_range(0, SEG), sess_win, $urandom);
			else
				send_item(KIND_DAT, s, SEG, sess_win, $urandom);
		end else if (r < 75)
			send_item(KIND_FIN, tracker.cum + $urandom_range(0, 3) * SEG,
				$urandom_range(0, SEG), $urandom, $urandom);
		else if (r < 79)
			send_item(KIND_RST, $urandom, $urandom_range(0, SEG), $urandom, $urandom);
		else if (r < 85) begin
			sess_win = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
			send_item(KIND_SYN, $urandom, $urandom_range(0, SEG), $urandom, $urandom);
		end else if (r < 92)
			send_item(KIND_DAT, $urandom, $urandom_range(0, SEG), sess_win, $urandom);
		else
			send_item(KIND_DAT, $urandom, $urandom_range(0, SEG), $urandom, $urandom);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		kind = KIND_SYN;
		seq_number = 0;
		payload_length = 0;
		window_slots = 0;
		payload_tag = 0;
		idle_cycles = 0;
		sess_win = 4;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: session open, reorder, old and out-of-window packets
		send_item(KIND_SYN, 32'hFFFF_FFFF, 0, 0, 0);
		send_item(KIND_DAT, 2 * SEG, SEG, 4, 16'h1111);
		send_item(KIND_DAT, SEG, SEG, 4, 16'hFFFF);
		send_item(KIND_DAT, 0, SEG, 4, 16'h0000);
		send_item(KIND_DAT, 0, 0, 4, 16'h2222);
		send_item(KIND_DAT, 32'hFFFF_FFFF, 11'h7FF & SEG, 4, 16'h3333);
		send_item(KIND_DAT, 32'h8000_0000, 0, 4, 16'h4444);
		// window full delivery
		send_item(KIND_DAT, 3 * SEG, SEG, 4, 16'h5555);
		// clamp of window size and size change
		send_item(KIND_DAT, 4 * SEG, 7, 0, 16'hA5A5);
		send_item(KIND_DAT, 4 * SEG + 7, 0, 15, 16'h5A5A);
		send_item(KIND_DAT, 4 * SEG + 7, 1, 9, 16'h0F0F);
		// fin ahead, then the gap is filled and the walk carries the ack past the fin
		send_item(KIND_FIN, 4 * SEG + 8 + SEG, 0, 0, 0);
		send_item(KIND_DAT, 4 * SEG + 8 + SEG, 1, 8, 16'h1234);
		send_item(KIND_DAT, 4 * SEG + 8, SEG, 8, 16'h4321);
		// fin at the cumulative ack, reset with filled slots, empty reset
		send_item(KIND_SYN, 0, 0, 0, 0);
		send_item(KIND_FIN, 0, 0, 0, 0);
		send_item(KIND_DAT, 0, SEG, 8, 16'hBEEF);
		send_item(KIND_DAT, 2 * SEG, SEG, 8, 16'hCAFE);
		send_item(KIND_RST, 0, 0, 0, 0);
		send_item(KIND_RST, 32'hFFFF_FFFF, 11'h7FF & SEG, 4'hF, 16'hFFFF);
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			random_item();
			// let the block run dry once in the middle
			if (i == N_RANDOM / 2) drain();
		end
		drain();

		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("selective_repeat_receive_window_tb passed");
		else
			$display("selective_repeat_receive_window_tb failed");
		$finish;
	end

endmodule
